>>> rtl/fcb_pkg.sv
// Shared definitions for the fade curve Bezier evaluator.
// Holds the default fraction width, shape mode codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fcb_pkg;

	// Default number of fraction bits of every Q1.F value.
	localparam int FRAC_BITS_DEF = 16;

	// Width of the configuration register index.
	localparam int CFG_INDEX_W = 2;

	// Curve shapes selected by the shape_mode register.
	typedef enum logic [1:0] {
		MODE_BENDED = 2'd0,
		MODE_SCURVE = 2'd1,
		MODE_LONG   = 2'd2,
		MODE_LINEAR = 2'd3
	} shape_mode_t;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_BEND      = 2'd0,
		REG_STRENGTH  = 2'd1,
		REG_SHAPE     = 2'd2,
		REG_FADE_OUT  = 2'd3
	} reg_index_t;

endpackage

`default_nettype wire

>>> rtl/fade_curve_bezier_eval.sv
// Fade envelope evaluator: cubic Bezier point (x, y) for a curve parameter t.
// An item moves through valid_s1, valid_s2, valid_s3 and done; one item is
// taken every cycle through a four stage multiplier pipeline, so busy stays low.
// Results cannot be held off: each is shown for exactly one cycle with done.
// Reset clears all valid bits and loads bend 0, strength 0.5, mode long, fade in.
// Depends on fcb_pkg, fcb_ctrl_pts, fcb_weights, fcb_blend and fcb_mulq.
`timescale 1ns / 1ps
`default_nettype none

module fade_curve_bezier_eval #(
	parameter int FRAC_BITS = fcb_pkg::FRAC_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [FRAC_BITS:0]             position,
	output logic                                done,
	output logic      [FRAC_BITS:0]             curve_x,
	output logic      [FRAC_BITS:0]             curve_y,
	input  wire logic                           cfg_we,
	input  wire logic [fcb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [FRAC_BITS:0]             cfg_data
);

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [FRAC_BITS:0]   bend_q;
	logic [FRAC_BITS:0]   strength_q;
	fcb_pkg::shape_mode_t shape_mode_q;
	logic                 fade_out_q;
	logic [FRAC_BITS:0]   p1x;
	logic [FRAC_BITS:0]   p1y;
	logic [FRAC_BITS:0]   p2x;
	logic [FRAC_BITS:0]   p2y;
	logic                 valid_s2;
	logic [FRAC_BITS:0]   w1_s2;
	logic [FRAC_BITS:0]   w2_s2;
	logic [FRAC_BITS:0]   w3_s2;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bend_q       <= '0;
			strength_q   <= ONE >> 1;
			shape_mode_q <= fcb_pkg::MODE_LONG;
			fade_out_q   <= 1'b0;
		end else if (cfg_we) begin
			case (fcb_pkg::reg_index_t'(cfg_index))
				fcb_pkg::REG_BEND:     bend_q       <= cfg_data;
				fcb_pkg::REG_STRENGTH: strength_q   <= cfg_data;
				fcb_pkg::REG_SHAPE:    shape_mode_q <= fcb_pkg::shape_mode_t'(cfg_data[1:0]);
				fcb_pkg::REG_FADE_OUT: fade_out_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	fcb_ctrl_pts #(.FRAC_BITS(FRAC_BITS)) u_ctrl_pts (
		.clk        (clk),
		.bend       (bend_q),
		.strength   (strength_q),
		.shape_mode (shape_mode_q),
		.fade_out   (fade_out_q),
		.p1x_q      (p1x),
		.p1y_q      (p1y),
		.p2x_q      (p2x),
		.p2y_q      (p2y)
	);

	fcb_weights #(.FRAC_BITS(FRAC_BITS)) u_weights (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start && !busy),
		.position (position),
		.valid_s2 (valid_s2),
		.w1_s2    (w1_s2),
		.w2_s2    (w2_s2),
		.w3_s2    (w3_s2)
	);

	fcb_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.w1_s2     (w1_s2),
		.w2_s2     (w2_s2),
		.w3_s2     (w3_s2),
		.p1x       (p1x),
		.p1y       (p1y),
		.p2x       (p2x),
		.p2y       (p2y),
		.fade_out  (fade_out_q),
		.done_q    (done),
		.curve_x_q (curve_x),
		.curve_y_q (curve_y)
	);

`ifndef SYNTHESIS
	// Every accepted item comes out with a done strobe.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##4 done)
		else $error("accepted item did not produce a result after four cycles");

	// A result is only shown when the weight stages held a valid item.
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(valid_s2, 2))
		else $error("result strobe without a matching item in the pipeline");

	// Both coordinates stay within 0..1.0.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (curve_x <= ONE) && (curve_y <= ONE))
		else $error("curve point outside 0..1.0");
`endif

endmodule

`default_nettype wire

>>> rtl/fcb_mulq.sv
// Fixed point multiply with round half up for Q1.F operands in 0..1.0.
// Combinational; used by the control point, weight and blend stages.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module fcb_mulq #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic [FRAC_BITS:0] a,
	input  wire logic [FRAC_BITS:0] b,
	output logic      [FRAC_BITS:0] p
);

	localparam int PW = 2 * FRAC_BITS + 2;

	logic [PW-1:0] prod;

	// Both operands are at most 1.0, so the rounded result never exceeds 1.0.
	assign prod = PW'(a) * PW'(b) + (PW'(1) << (FRAC_BITS - 1));
	assign p    = prod[FRAC_BITS +: FRAC_BITS + 1];

endmodule

`default_nettype wire

>>> rtl/fcb_ctrl_pts.sv
// Derives the two inner Bezier control points from bend, strength, mode
// and fade direction, registered once per cycle. Uses fcb_pkg and fcb_mulq.
`timescale 1ns / 1ps
`default_nettype none

module fcb_ctrl_pts #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic [FRAC_BITS:0]  bend,
	input  wire logic [FRAC_BITS:0]  strength,
	input  wire fcb_pkg::shape_mode_t shape_mode,
	input  wire logic                fade_out,
	output logic      [FRAC_BITS:0]  p1x_q,
	output logic      [FRAC_BITS:0]  p1y_q,
	output logic      [FRAC_BITS:0]  p2x_q,
	output logic      [FRAC_BITS:0]  p2y_q
);

	localparam logic [FRAC_BITS:0] ONE     = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	localparam logic [FRAC_BITS:0] QUARTER = ONE >> 2;

	logic [FRAC_BITS:0] b_sat;
	logic [FRAC_BITS:0] s_sat;
	logic [FRAC_BITS:0] b_inv;
	logic [FRAC_BITS:0] sb;
	logic [FRAC_BITS:0] sn;
	logic [FRAC_BITS:0] p1x_d;
	logic [FRAC_BITS:0] p1y_d;
	logic [FRAC_BITS:0] p2x_d;
	logic [FRAC_BITS:0] p2y_d;

	assign b_sat = (bend > ONE) ? ONE : bend;
	assign s_sat = (strength > ONE) ? ONE : strength;
	assign b_inv = ONE - b_sat;

	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_sb (.a(s_sat), .b(b_sat), .p(sb));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_sn (.a(s_sat), .b(b_inv), .p(sn));

	always_comb begin
		p1x_d = sn;
		p1y_d = sb;
		p2x_d = ONE - sn;
		p2y_d = ONE - sb;
		case (shape_mode)
			fcb_pkg::MODE_BENDED: begin
				if (!fade_out) begin
					p2x_d = ONE - sb;
					p2y_d = ONE - sn;
				end else begin
					p1x_d = sb;
					p1y_d = sn;
				end
			end
			fcb_pkg::MODE_SCURVE: begin
			end
			fcb_pkg::MODE_LONG: begin
				if (!fade_out) begin
					p2x_d = ONE;
					p2y_d = ONE;
				end else begin
					p1x_d = '0;
					p1y_d = '0;
				end
			end
			default: begin
				// Linear mode falls back to a straight line.
				p1x_d = QUARTER;
				p1y_d = QUARTER;
				p2x_d = ONE - QUARTER;
				p2y_d = ONE - QUARTER;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p1x_q <= p1x_d;
		p1y_q <= p1y_d;
		p2x_q <= p2x_d;
		p2y_q <= p2y_d;
	end

endmodule

`default_nettype wire

>>> rtl/fcb_weights.sv
// Two pipeline stages that turn the curve parameter t into the Bernstein
// weights t*(1-t)^2, t^2*(1-t) and t^3. Uses fcb_mulq.
`timescale 1ns / 1ps
`default_nettype none

module fcb_weights #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [FRAC_BITS:0] position,
	output logic                    valid_s2,
	output logic      [FRAC_BITS:0] w1_s2,
	output logic      [FRAC_BITS:0] w2_s2,
	output logic      [FRAC_BITS:0] w3_s2
);

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

	logic [FRAC_BITS:0] t;
	logic [FRAC_BITS:0] u;
	logic [FRAC_BITS:0] tt;
	logic [FRAC_BITS:0] uu;
	logic               valid_s1;
	logic [FRAC_BITS:0] t_s1;
	logic [FRAC_BITS:0] u_s1;
	logic [FRAC_BITS:0] tt_s1;
	logic [FRAC_BITS:0] uu_s1;
	logic [FRAC_BITS:0] w1;
	logic [FRAC_BITS:0] w2;
	logic [FRAC_BITS:0] w3;

	assign t = (position > ONE) ? ONE : position;
	assign u = ONE - t;

	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_tt (.a(t), .b(t), .p(tt));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_uu (.a(u), .b(u), .p(uu));

	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_w1 (.a(t_s1),  .b(uu_s1), .p(w1));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_w2 (.a(tt_s1), .b(u_s1),  .p(w2));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_w3 (.a(tt_s1), .b(t_s1),  .p(w3));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		t_s1  <= t;
		u_s1  <= u;
		tt_s1 <= tt;
		uu_s1 <= uu;
		w1_s2 <= w1;
		w2_s2 <= w2;
		w3_s2 <= w3;
	end

endmodule

`default_nettype wire

>>> rtl/fcb_blend.sv
// Last two pipeline stages: scales the weights by the control points, sums
// each coordinate, saturates to 1.0 and inverts y for a fade out. Uses fcb_mulq.
`timescale 1ns / 1ps
`default_nettype none

module fcb_blend #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               valid_s2,
	input  wire logic [FRAC_BITS:0] w1_s2,
	input  wire logic [FRAC_BITS:0] w2_s2,
	input  wire logic [FRAC_BITS:0] w3_s2,
	input  wire logic [FRAC_BITS:0] p1x,
	input  wire logic [FRAC_BITS:0] p1y,
	input  wire logic [FRAC_BITS:0] p2x,
	input  wire logic [FRAC_BITS:0] p2y,
	input  wire logic               fade_out,
	output logic                    done_q,
	output logic      [FRAC_BITS:0] curve_x_q,
	output logic      [FRAC_BITS:0] curve_y_q
);

	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;
	// 3*a + 3*b + c with a, b, c at most 1.0 stays below 8.0.
	localparam int SW = FRAC_BITS + 4;

	logic [FRAC_BITS:0] m1x;
	logic [FRAC_BITS:0] m2x;
	logic [FRAC_BITS:0] m1y;
	logic [FRAC_BITS:0] m2y;
	logic               valid_s3;
	logic [FRAC_BITS:0] m1x_s3;
	logic [FRAC_BITS:0] m2x_s3;
	logic [FRAC_BITS:0] m1y_s3;
	logic [FRAC_BITS:0] m2y_s3;
	logic [FRAC_BITS:0] w3_s3;
	logic [SW-1:0]      pair_x;
	logic [SW-1:0]      pair_y;
	logic [SW-1:0]      sum_x;
	logic [SW-1:0]      sum_y;
	logic [FRAC_BITS:0] sat_x;
	logic [FRAC_BITS:0] sat_y;

	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_1x (.a(p1x), .b(w1_s2), .p(m1x));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_2x (.a(p2x), .b(w2_s2), .p(m2x));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_1y (.a(p1y), .b(w1_s2), .p(m1y));
	fcb_mulq #(.FRAC_BITS(FRAC_BITS)) u_mul_2y (.a(p2y), .b(w2_s2), .p(m2y));

	assign pair_x = SW'(m1x_s3) + SW'(m2x_s3);
	assign pair_y = SW'(m1y_s3) + SW'(m2y_s3);
	assign sum_x  = (pair_x << 1) + pair_x + SW'(w3_s3);
	assign sum_y  = (pair_y << 1) + pair_y + SW'(w3_s3);
	assign sat_x  = (sum_x > SW'(ONE)) ? ONE : sum_x[FRAC_BITS:0];
	assign sat_y  = (sum_y > SW'(ONE)) ? ONE : sum_y[FRAC_BITS:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		m1x_s3    <= m1x;
		m2x_s3    <= m2x;
		m1y_s3    <= m1y;
		m2y_s3    <= m2y;
		w3_s3     <= w3_s2;
		curve_x_q <= sat_x;
		curve_y_q <= fade_out ? (ONE - sat_y) : sat_y;
	end

endmodule

`default_nettype wire
